>>> design/sorted_matrix_staircase_search_top_macros.svh
// assertion macros for the staircase search block
// used by sorted_matrix_staircase_search_top; expects clk and arst_n in scope
`ifndef SORTED_MATRIX_STAIRCASE_SEARCH_TOP_MACROS_SVH
`define SORTED_MATRIX_STAIRCASE_SEARCH_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define SMS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled in reset
`define SMS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/sms_pkg.sv
// shared constants for the staircase search block
// no dependencies
package sms_pkg;

	localparam int DEF_MAX_ROWS = 64;
	localparam int DEF_MAX_COLS = 64;

	localparam int DATA_W  = 32;
	localparam int COUNT_W = 7;
	localparam int COORD_W = 6;

	localparam logic [COUNT_W-1:0] ROW_COUNT_RST = 7'd4;
	localparam logic [COUNT_W-1:0] COL_COUNT_RST = 7'd4;

	// command codes
	localparam logic CMD_WRITE  = 1'b0;
	localparam logic CMD_SEARCH = 1'b1;

	// register indexes
	localparam logic REG_ROW_COUNT = 1'b0;
	localparam logic REG_COL_COUNT = 1'b1;

endpackage

>>> design/sms_ram.sv
// simple dual-port matrix store: one write port, one registered read port
// depends on sms_pkg for the data width
module sms_ram #(
	parameter int ADDR_W = 12
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [ADDR_W-1:0]         waddr,
	input  logic [sms_pkg::DATA_W-1:0] wdata,
	input  logic                      re,
	input  logic [ADDR_W-1:0]         raddr,
	output logic [sms_pkg::DATA_W-1:0] rdata
);
	import sms_pkg::*;

	localparam int DEPTH = 1 << ADDR_W;

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> design/sorted_matrix_staircase_search_top.sv
// top level of the staircase search over a row- and column-sorted matrix
// depends on sms_pkg, sms_ram and sorted_matrix_staircase_search_top_macros.svh
//
// Holds up to MAX_ROWS x MAX_COLS signed 32-bit entries in one synchronous
// memory (entry at {row, col}). A write beat (cmd = write) stores one entry in
// its accept cycle and gives no result; rows or columns past the store are
// dropped. A search beat walks from the top-right corner of the region set by
// row_count and col_count (each clipped to the store size): equal entry is a
// hit, a larger key moves down a row, a smaller key moves left a column, and
// leaving the region is a miss (found_row and found_col zero). Each step of
// the walk is a memory read state followed by a compare state; a walk has
// at most rows + cols - 1 steps, and a miss ends in one more read state
// that finds the walk outside the region. A finished result waits in the
// done state while the output register is full and stalled. The block
// works on one beat at a time; the result sits in an output register, so a
// new beat is taken while the previous result still waits on out_stall.
// Only entries that have been written may be reached by a search.
module sorted_matrix_staircase_search_top #(
	parameter int MAX_ROWS = sms_pkg::DEF_MAX_ROWS,
	parameter int MAX_COLS = sms_pkg::DEF_MAX_COLS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [sms_pkg::COUNT_W-1:0] cfg_wdata,
	// input channel
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        cmd,
	input  logic [sms_pkg::COORD_W-1:0] entry_row,
	input  logic [sms_pkg::COORD_W-1:0] entry_col,
	input  logic signed [sms_pkg::DATA_W-1:0] entry_value,
	input  logic signed [sms_pkg::DATA_W-1:0] search_key,
	// output channel
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        found,
	output logic [sms_pkg::COORD_W-1:0] found_row,
	output logic [sms_pkg::COORD_W-1:0] found_col
);
	import sms_pkg::*;

	`include "sorted_matrix_staircase_search_top_macros.svh"

	localparam int RIDX_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CIDX_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int ADDR_W = RIDX_W + CIDX_W;
	// scratch widths for zero-extending before the index part-select
	localparam int RCNT_EXT_W = RIDX_W + COUNT_W;
	localparam int CCNT_EXT_W = CIDX_W + COUNT_W;
	localparam int RCRD_EXT_W = RIDX_W + COORD_W;
	localparam int CCRD_EXT_W = CIDX_W + COORD_W;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_READ = 4'b0010,
		ST_CMP  = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t state_q;

	logic [COUNT_W-1:0] row_count_q;
	logic [COUNT_W-1:0] col_count_q;

	// walk registers: r_q is the current row, c_q is one past the current column
	logic [COUNT_W-1:0] rows_q;
	logic [COUNT_W-1:0] r_q;
	logic [COUNT_W-1:0] c_q;
	logic signed [DATA_W-1:0] key_q;
	logic               hit_q;

	logic               out_valid_q;
	logic               found_q;
	logic [COORD_W-1:0] found_row_q;
	logic [COORD_W-1:0] found_col_q;

	logic               in_acc;
	logic               out_free;
	logic [COUNT_W-1:0] rows_clip;
	logic [COUNT_W-1:0] cols_clip;
	logic [COUNT_W-1:0] c_m1;
	logic               walk_out;

	logic [RCNT_EXT_W-1:0] r_ext;
	logic [CCNT_EXT_W-1:0] c_ext;
	logic [RCRD_EXT_W-1:0] wr_row_ext;
	logic [CCRD_EXT_W-1:0] wr_col_ext;

	logic               mem_we;
	logic [ADDR_W-1:0]  mem_waddr;
	logic               mem_re;
	logic [ADDR_W-1:0]  mem_raddr;
	logic signed [DATA_W-1:0] mem_rdata;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// counts beyond the store are clipped to its size
	assign rows_clip = (32'(row_count_q) > MAX_ROWS) ? COUNT_W'(MAX_ROWS) : row_count_q;
	assign cols_clip = (32'(col_count_q) > MAX_COLS) ? COUNT_W'(MAX_COLS) : col_count_q;

	assign c_m1     = c_q - COUNT_W'(1);
	assign walk_out = (r_q >= rows_q) || (c_q == '0);

	// read address of the current entry
	assign r_ext     = RCNT_EXT_W'(r_q);
	assign c_ext     = CCNT_EXT_W'(c_m1);
	assign mem_raddr = {r_ext[RIDX_W-1:0], c_ext[CIDX_W-1:0]};
	assign mem_re    = (state_q == ST_READ) && !walk_out;

	// write port: entries outside the store are dropped
	assign wr_row_ext = RCRD_EXT_W'(entry_row);
	assign wr_col_ext = CCRD_EXT_W'(entry_col);
	assign mem_waddr  = {wr_row_ext[RIDX_W-1:0], wr_col_ext[CIDX_W-1:0]};
	assign mem_we     = in_acc && (cmd == CMD_WRITE)
			&& (32'(entry_row) < MAX_ROWS) && (32'(entry_col) < MAX_COLS);

	sms_ram #(
		.ADDR_W(ADDR_W)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(entry_value),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= ROW_COUNT_RST;
			col_count_q <= COL_COUNT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ROW_COUNT: row_count_q <= cfg_wdata;
				REG_COL_COUNT: col_count_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// walk sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rows_q  <= '0;
			r_q     <= '0;
			c_q     <= '0;
			hit_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc && (cmd == CMD_SEARCH)) begin
						rows_q  <= rows_clip;
						r_q     <= '0;
						c_q     <= cols_clip;
						hit_q   <= 1'b0;
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					// walked out of the region: miss
					if (walk_out) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					if (key_q == mem_rdata) begin
						hit_q   <= 1'b1;
						state_q <= ST_DONE;
					end else if (key_q > mem_rdata) begin
						r_q     <= r_q + COUNT_W'(1);
						state_q <= ST_READ;
					end else begin
						c_q     <= c_m1;
						state_q <= ST_READ;
					end
				end
				ST_DONE: begin
					// wait for room in the output register
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// key captured with the search beat
	always_ff @(posedge clk) begin
		if (in_acc && (cmd == CMD_SEARCH)) begin
			key_q <= search_key;
		end
	end

	// output register, loaded when a search finishes and the slot is free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_DONE) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && out_free) begin
			found_q     <= hit_q;
			found_row_q <= hit_q ? r_q[COORD_W-1:0] : '0;
			found_col_q <= hit_q ? c_m1[COORD_W-1:0] : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign found     = found_q;
	assign found_row = found_row_q;
	assign found_col = found_col_q;

	// a compare only follows a read issued inside the region
	`SMS_ASSERT_NOW(a_cmp_in_region, state_q == ST_CMP, (r_q < rows_q) && (c_q != '0), "compare outside the walk region")
	// a miss reports zero coordinates
	`SMS_ASSERT_NOW(a_miss_zero, out_valid && !found, (found_row == '0) && (found_col == '0), "miss with nonzero coordinates")
	// a read is always followed by its compare
	`SMS_ASSERT_NEXT(a_read_then_cmp, mem_re, state_q == ST_CMP, "memory read without compare")
	// a finished search never overwrites a result still waiting
	`SMS_ASSERT_NEXT(a_no_overwrite, (state_q == ST_DONE) && out_valid_q && out_stall, state_q == ST_DONE, "result dropped while output stalled")

endmodule

>>> tb/sorted_matrix_staircase_search_top_test.sv
`timescale 1ns / 1ps
// self-checking bench for sorted_matrix_staircase_search_top: sorted grids, staircase
// searches and stray writes, checked against a staircase walk over a local copy of the grid
// depends on sms_pkg and the design sources only

module sorted_matrix_staircase_search_top_test;
	import sms_pkg::*;

	localparam int DIM_ROWS       = DEF_MAX_ROWS;
	localparam int DIM_COLS       = DEF_MAX_COLS;
	// longest walk is rows + cols - 1 steps; the drain time covers it plus margin
	localparam int DRAIN_CYCLES   = 2 * (DIM_ROWS + DIM_COLS) + 4;
	localparam int WATCHDOG_LIMIT = 6000;
	localparam int BEAT_TARGET    = 1900;
	localparam longint WORD_MIN   = -64'sd2147483648;
	localparam longint WORD_MAX   = 64'sd2147483647;

	// hand-built 4x4 grid, rows and columns ascending, word extremes in the corners
	localparam longint CORNER_GRID [16] = '{
		WORD_MIN, -100, -10, 0,
		-90,      -50,  0,   5,
		-80,      -40,  7,   50,
		-70,      3,    8,   WORD_MAX
	};

	typedef struct {
		logic                     op;
		logic [COORD_W-1:0]       row;
		logic [COORD_W-1:0]       col;
		logic signed [DATA_W-1:0] value;
		logic signed [DATA_W-1:0] probe;
	} beat_t;

	typedef struct {
		logic               hit;
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
	} answer_t;

	logic                     clk         = 1'b0;
	logic                     arst_n      = 1'b0;
	logic                     cfg_we      = 1'b0;
	logic                     cfg_index   = REG_ROW_COUNT;
	logic [COUNT_W-1:0]       cfg_wdata   = '0;
	logic                     in_valid    = 1'b0;
	logic                     in_stall;
	logic                     cmd         = CMD_WRITE;
	logic [COORD_W-1:0]       entry_row   = '0;
	logic [COORD_W-1:0]       entry_col   = '0;
	logic signed [DATA_W-1:0] entry_value = '0;
	logic signed [DATA_W-1:0] search_key  = '0;
	logic                     out_valid;
	logic                     out_stall   = 1'b0;
	logic                     found;
	logic [COORD_W-1:0]       found_row;
	logic [COORD_W-1:0]       found_col;

	beat_t   queued_beats [$];
	answer_t pending_answers [$];
	beat_t   next_beat;
	answer_t head_answer;

	// local copy of the store and the two count registers
	logic signed [DATA_W-1:0] matrix_copy [0:DIM_ROWS-1][0:DIM_COLS-1];
	logic [COUNT_W-1:0]       rows_setting = ROW_COUNT_RST;
	logic [COUNT_W-1:0]       cols_setting = COL_COUNT_RST;

	// grid contents intended by the current phase, used to pick search keys
	longint plan [0:DIM_ROWS-1][0:DIM_COLS-1];

	int   mismatches   = 0;
	int   beats_queued = 0;
	int   quiet_cycles = 0;
	logic in_taken     = 1'b0;
	bit   source_steady = 1'b0;
	bit   sink_steady   = 1'b0;
	int   burst_left   = 0;
	int   gap_left     = 0;
	int   stall_left   = 0;
	int   open_left    = 0;

	sorted_matrix_staircase_search_top u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cmd         (cmd),
		.entry_row   (entry_row),
		.entry_col   (entry_col),
		.entry_value (entry_value),
		.search_key  (search_key),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.found       (found),
		.found_row   (found_row),
		.found_col   (found_col)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// walk from the top-right corner of the region in use
	function automatic answer_t staircase_walk(input logic signed [DATA_W-1:0] probe);
		answer_t ans;
		int      rows_used;
		int      cols_used;
		int      r;
		int      c;
		rows_used = (rows_setting > DIM_ROWS) ? DIM_ROWS : rows_setting;
		cols_used = (cols_setting > DIM_COLS) ? DIM_COLS : cols_setting;
		ans.hit = 1'b0;
		ans.row = '0;
		ans.col = '0;
		r = 0;
		c = cols_used;
		while (r < rows_used && c > 0 && !ans.hit) begin
			if (probe == matrix_copy[r][c-1])
				ans.hit = 1'b1;
			else if (probe > matrix_copy[r][c-1])
				r++;
			else
				c--;
		end
		if (ans.hit) begin
			ans.row = COORD_W'(r);
			ans.col = COORD_W'(c - 1);
		end
		return ans;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch at %0t ns: %s got %0d, expected %0d", $time, what, got, want);
		mismatches++;
	endtask

	// predictor, result check and watchdog, all on the rising edge
	always @(posedge clk) begin
		if (!arst_n) begin
			in_taken <= 1'b0;
		end else begin
			in_taken <= in_valid && !in_stall;
			if (in_valid && !in_stall) begin
				if (cmd == CMD_WRITE)
					matrix_copy[entry_row][entry_col] = entry_value;
				else
					pending_answers.push_back(staircase_walk(search_key));
			end
			if (out_valid && !out_stall) begin
				if (pending_answers.size() == 0) begin
					report_mismatch("result beat with no search waiting, found", found, 0);
				end else begin
					head_answer = pending_answers.pop_front();
					if (found !== head_answer.hit)
						report_mismatch("found", found, head_answer.hit);
					if (found_row !== head_answer.row)
						report_mismatch("found_row", found_row, head_answer.row);
					if (found_col !== head_answer.col)
						report_mismatch("found_col", found_col, head_answer.col);
				end
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout: no beat moved for %0d cycles", WATCHDOG_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// input driver: bursts of beats with random gaps between them
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_taken)) begin
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (queued_beats.size() != 0) begin
				next_beat = queued_beats.pop_front();
				cmd         <= next_beat.op;
				entry_row   <= next_beat.row;
				entry_col   <= next_beat.col;
				entry_value <= next_beat.value;
				search_key  <= next_beat.probe;
				in_valid    <= 1'b1;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 10);
					if (source_steady)
						gap_left = 0;
					else if ($urandom_range(0, 4) == 0)
						gap_left = $urandom_range(8, 20);
					else
						gap_left = $urandom_range(0, 3);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result stall: alternating stall and open runs, independent of out_valid
	always @(negedge clk) begin
		if (sink_steady) begin
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (open_left > 0) begin
			open_left--;
			out_stall <= 1'b0;
		end else begin
			stall_left = $urandom_range(1, 8);
			open_left  = $urandom_range(0, 6);
			out_stall <= 1'b0;
		end
	end

	// quiet point between edges where the queues are not being touched
	task automatic settle();
		@(posedge clk);
		#0.5;
	endtask

	task automatic wait_idle();
		do
			settle();
		while (queued_beats.size() != 0 || in_valid || pending_answers.size() != 0);
	endtask

	task automatic set_count(input logic reg_sel, input logic [COUNT_W-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= reg_sel;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (reg_sel == REG_ROW_COUNT)
			rows_setting = value;
		else
			cols_setting = value;
	endtask

	task automatic queue_write(input int r, input int c, input longint value);
		beat_t b;
		b.op    = CMD_WRITE;
		b.row   = COORD_W'(r);
		b.col   = COORD_W'(c);
		b.value = DATA_W'(value);
		b.probe = $urandom;
		queued_beats.push_back(b);
		beats_queued++;
	endtask

	// ignored fields of a search carry random bits
	task automatic queue_search(input longint probe);
		beat_t b;
		b.op    = CMD_SEARCH;
		b.row   = COORD_W'($urandom);
		b.col   = COORD_W'($urandom);
		b.value = $urandom;
		b.probe = DATA_W'(probe);
		queued_beats.push_back(b);
		beats_queued++;
	endtask

	// sorted grid: each entry is the larger of its upper and left neighbors plus a step
	task automatic fill_plan(input int rows, input int cols);
		int          kind;
		int          w;
		int unsigned step_max;
		longint      base;
		longint      up;
		longint      left;
		longint      v;
		kind = $urandom_range(0, 4);
		w = $urandom;
		case (kind)
			0: begin
				base = w;
				step_max = 1000;
			end
			1: begin
				base = WORD_MIN;
				step_max = 1 << 24;
			end
			2: begin
				// saturates at the top, so many entries equal the largest word
				base = WORD_MAX - $urandom_range(0, 5000);
				step_max = 200;
			end
			3: begin
				// narrow range, lots of duplicates
				w = $urandom_range(0, 100);
				base = w - 50;
				step_max = 2;
			end
			default: begin
				base = WORD_MIN + $urandom_range(0, 1 << 20);
				step_max = 1 << 26;
			end
		endcase
		for (int r = 0; r < rows; r++) begin
			for (int c = 0; c < cols; c++) begin
				if (r == 0 && c == 0) begin
					v = base;
				end else begin
					up   = (r > 0) ? plan[r-1][c] : WORD_MIN;
					left = (c > 0) ? plan[r][c-1] : WORD_MIN;
					v    = ((up > left) ? up : left) + $urandom_range(0, step_max);
				end
				plan[r][c] = (v > WORD_MAX) ? WORD_MAX : v;
			end
		end
	endtask

	task automatic queue_region(input int rows, input int cols);
		if ($urandom_range(0, 1)) begin
			for (int r = 0; r < rows; r++)
				for (int c = 0; c < cols; c++)
					queue_write(r, c, plan[r][c]);
		end else begin
			for (int c = 0; c < cols; c++)
				for (int r = 0; r < rows; r++)
					queue_write(r, c, plan[r][c]);
		end
	endtask

	// mostly keys present in the grid, then near misses, random words and extremes
	function automatic longint pick_probe(input int rows, input int cols);
		int sel;
		int r;
		int c;
		int w;
		w = $urandom;
		if (rows == 0 || cols == 0)
			return w;
		r = $urandom_range(0, rows - 1);
		c = $urandom_range(0, cols - 1);
		sel = $urandom_range(0, 99);
		if (sel < 55)
			return plan[r][c];
		if (sel < 62)
			return plan[r][c] + 1;
		if (sel < 70)
			return plan[r][c] - 1;
		if (sel < 90)
			return w;
		return $urandom_range(0, 1) ? WORD_MAX : WORD_MIN;
	endfunction

	// one setting of the counts: fresh sorted region, then searches and stray writes
	task automatic run_phase(input int rows_cfg, input int cols_cfg, input int searches);
		int rows;
		int cols;
		int pause_at;
		int r;
		int c;
		int w;
		bit scramble;
		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if ($urandom_range(0, 1)) begin
			set_count(REG_ROW_COUNT, COUNT_W'(rows_cfg));
			set_count(REG_COL_COUNT, COUNT_W'(cols_cfg));
		end else begin
			set_count(REG_COL_COUNT, COUNT_W'(cols_cfg));
			set_count(REG_ROW_COUNT, COUNT_W'(rows_cfg));
		end
		rows = (rows_cfg > DIM_ROWS) ? DIM_ROWS : rows_cfg;
		cols = (cols_cfg > DIM_COLS) ? DIM_COLS : cols_cfg;
		source_steady = ($urandom_range(0, 3) == 0);
		sink_steady   = ($urandom_range(0, 3) == 0);
		// some phases break the ordering with stray writes inside the region
		scramble = ($urandom_range(0, 4) == 0);
		pause_at = ($urandom_range(0, 2) == 0) ? $urandom_range(0, searches - 1) : -1;
		settle();
		if (rows > 0 && cols > 0) begin
			fill_plan(rows, cols);
			queue_region(rows, cols);
		end
		for (int i = 0; i < searches; i++) begin
			if (i == pause_at)
				wait_idle();
			if ($urandom_range(0, 9) == 0) begin
				r = $urandom_range(0, DIM_ROWS - 1);
				c = $urandom_range(0, DIM_COLS - 1);
				w = $urandom;
				if (!scramble && r < rows && c < cols) begin
					if (cols < DIM_COLS)
						c = $urandom_range(cols, DIM_COLS - 1);
					else if (rows < DIM_ROWS)
						r = $urandom_range(rows, DIM_ROWS - 1);
				end
				queue_write(r, c, w);
			end
			queue_search(pick_probe(rows, cols));
		end
	endtask

	initial begin
		int sel;
		int rows_cfg;
		int cols_cfg;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		settle();

		// directed: counts left at reset, corner extremes, duplicate at the start corner
		for (int i = 0; i < 16; i++)
			plan[i / 4][i % 4] = CORNER_GRID[i];
		queue_region(4, 4);
		queue_search(WORD_MIN);
		queue_search(WORD_MAX);
		queue_search(0);
		queue_search(-70);
		queue_search(6);
		queue_search(WORD_MAX - 1);
		queue_search(WORD_MIN + 1);
		// hold the sender until every search has answered
		wait_idle();

		// extreme counts: full height, full width, saturated, empty region
		run_phase(64, 2, $urandom_range(20, 40));
		run_phase(3, 64, $urandom_range(20, 40));
		run_phase(127, 1, $urandom_range(20, 40));
		run_phase(1, 127, $urandom_range(20, 40));
		run_phase(0, 5, $urandom_range(10, 20));
		run_phase(5, 0, $urandom_range(10, 20));
		run_phase(0, 0, $urandom_range(10, 20));
		run_phase(1, 1, $urandom_range(20, 40));

		while (beats_queued < BEAT_TARGET) begin
			sel = $urandom_range(0, 19);
			if (sel < 14) begin
				rows_cfg = $urandom_range(1, 8);
				cols_cfg = $urandom_range(1, 8);
			end else if (sel < 16) begin
				rows_cfg = $urandom_range(9, 24);
				cols_cfg = $urandom_range(1, 6);
			end else if (sel < 17) begin
				rows_cfg = $urandom_range(1, 6);
				cols_cfg = $urandom_range(9, 24);
			end else if (sel < 18) begin
				rows_cfg = $urandom_range(65, 127);
				cols_cfg = $urandom_range(1, 3);
			end else if (sel < 19) begin
				rows_cfg = $urandom_range(1, 3);
				cols_cfg = $urandom_range(65, 127);
			end else begin
				rows_cfg = $urandom_range(0, 1) ? 0 : $urandom_range(0, 8);
				cols_cfg = (rows_cfg == 0) ? $urandom_range(0, 8) : 0;
			end
			run_phase(rows_cfg, cols_cfg, $urandom_range(15, 45));
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
